// File: rtl/core/aqkb_pkg.sv
`timescale 1ns / 1ps
// Package for the accelerated quadrature knob bank: word types, register
// indexes, thresholds and the quadrature step decoder. No dependencies.
package aqkb_pkg;

    localparam int KNOB_W   = 4;
    localparam int VALUE_W  = 7;
    localparam int POS_W    = 8;
    localparam int WAIT_W   = 10;
    localparam int TIME_W   = 32;
    localparam int MULT_W   = 3;
    localparam int THRESH_W = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [POS_W-1:0]  POS_MAX  = 8'd254;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 10'd1023;

    localparam logic [THRESH_W-1:0] RST_VERY_FAST   = 10'd100;
    localparam logic [THRESH_W-1:0] RST_FAST        = 10'd150;
    localparam logic [THRESH_W-1:0] RST_MEDIUM_FAST = 10'd200;
    localparam logic [THRESH_W-1:0] RST_MEDIUM      = 10'd250;

    localparam logic [MULT_W-1:0] MULT_X1 = 3'd1;
    localparam logic [MULT_W-1:0] MULT_X2 = 3'd2;
    localparam logic [MULT_W-1:0] MULT_X3 = 3'd3;
    localparam logic [MULT_W-1:0] MULT_X4 = 3'd4;
    localparam logic [MULT_W-1:0] MULT_X5 = 3'd5;

    // Old/new A/B codes that move the knob one detent up or down.
    localparam logic [3:0] CODE_UP_0 = 4'b1101;
    localparam logic [3:0] CODE_UP_1 = 4'b0100;
    localparam logic [3:0] CODE_UP_2 = 4'b0010;
    localparam logic [3:0] CODE_UP_3 = 4'b1011;
    localparam logic [3:0] CODE_DN_0 = 4'b1110;
    localparam logic [3:0] CODE_DN_1 = 4'b0111;
    localparam logic [3:0] CODE_DN_2 = 4'b0001;
    localparam logic [3:0] CODE_DN_3 = 4'b1000;

    typedef enum logic {
        KIND_PIN  = 1'b0,
        KIND_SYNC = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH_VERY_FAST   = 8'd0,
        REG_THRESH_FAST        = 8'd1,
        REG_THRESH_MEDIUM_FAST = 8'd2,
        REG_THRESH_MEDIUM      = 8'd3
    } reg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [KNOB_W-1:0]   knob;
        logic                phase_a;
        logic                phase_b;
        logic [TIME_W-1:0]   now_ms;
        logic [VALUE_W-1:0]  sync_value;
    } req_word_t;

    typedef struct packed {
        logic [KNOB_W-1:0]  knob_out;
        logic [VALUE_W-1:0] knob_value;
    } rsp_word_t;

    typedef struct packed {
        logic [THRESH_W-1:0] very_fast;
        logic [THRESH_W-1:0] fast;
        logic [THRESH_W-1:0] medium_fast;
        logic [THRESH_W-1:0] moderate;
    } thresh_t;

    function automatic dir_t step_dir(input logic [3:0] code);
        dir_t d;
        case (code) inside
            CODE_UP_0, CODE_UP_1, CODE_UP_2, CODE_UP_3: d = DIR_UP;
            CODE_DN_0, CODE_DN_1, CODE_DN_2, CODE_DN_3: d = DIR_DOWN;
            default:                                    d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/aqkb_cfg_regs.sv
`timescale 1ns / 1ps
// Threshold register file of the knob bank, written over the config channel.
// Depends on aqkb_pkg.
module aqkb_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aqkb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aqkb_pkg::THRESH_W-1:0]  cfg_data,
    output aqkb_pkg::thresh_t              thresh
);
    import aqkb_pkg::*;

    thresh_t thresh_reg;
    thresh_t thresh_next;

    assign cfg_ready = 1'b1;
    assign thresh    = thresh_reg;

    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESH_VERY_FAST:   thresh_next.very_fast   = cfg_data;
                REG_THRESH_FAST:        thresh_next.fast        = cfg_data;
                REG_THRESH_MEDIUM_FAST: thresh_next.medium_fast = cfg_data;
                REG_THRESH_MEDIUM:      thresh_next.moderate    = cfg_data;
                default:                thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.very_fast   <= RST_VERY_FAST;
            thresh_reg.fast        <= RST_FAST;
            thresh_reg.medium_fast <= RST_MEDIUM_FAST;
            thresh_reg.moderate    <= RST_MEDIUM;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

endmodule

// File: rtl/core/accelerated_quadrature_knob_bank_unit.sv
`timescale 1ns / 1ps
// Top level of the accelerated quadrature knob bank.
// Depends on aqkb_pkg and aqkb_cfg_regs.
//
// Usage:
//   req carries one word per knob event: a pin sample (A/B levels plus a
//   millisecond time) or a host sync write. Every request word yields exactly
//   one rsp word with the knob index and the knob position halved, or zero
//   for a knob out of range. cfg writes one of the four speed thresholds;
//   write only while idle. rsp_valid rises once an accepted word moves from
//   the input register to the output register. One word is accepted every
//   cycle while rsp_ready is high: a word is registered, then the knob state
//   is read, updated and written back as the result enters the output
//   register, so back-to-back words on the same knob see each other's
//   updates. Per-knob state and the wait history sit in flops. When the
//   receiver stalls, the result holds in the output register; the input
//   register takes one more word, then req_ready drops until rsp_ready returns.
//   Reset clears all knob state (positions, wait history, multipliers to one)
//   and loads the default thresholds; the block takes words right after.
module accelerated_quadrature_knob_bank_unit #(
    parameter int NUM_KNOBS  = 16,
    parameter int RING_DEPTH = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  aqkb_pkg::req_word_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output aqkb_pkg::rsp_word_t            rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [aqkb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aqkb_pkg::THRESH_W-1:0]  cfg_data
);
    import aqkb_pkg::*;

    localparam int KIDX_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W  = $clog2(RING_DEPTH * 1023 + 1);

    typedef logic [RING_DEPTH-1:0][WAIT_W-1:0] ring_row_t;

    thresh_t thresh;

    aqkb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh)
    );

    // Input and output registers.
    logic      in_valid_reg;
    req_word_t in_word_reg;
    logic      out_valid_reg;
    rsp_word_t out_word_reg;

    // Per-knob state.
    logic [POS_W-1:0]  pos_reg      [NUM_KNOBS];
    logic [1:0]        prev_code_reg[NUM_KNOBS];
    logic [POS_W-1:0]  prev_pos_reg [NUM_KNOBS];
    logic [MULT_W-1:0] mult_reg     [NUM_KNOBS];
    logic [SLOT_W-1:0] slot_reg     [NUM_KNOBS];
    ring_row_t         ring_reg     [NUM_KNOBS];
    logic [SUM_W-1:0]  sum_reg      [NUM_KNOBS];
    logic [TIME_W-1:0] last_reg     [NUM_KNOBS];
    logic [POS_W-1:0]  ovpos_reg    [NUM_KNOBS];
    logic              ovon_reg     [NUM_KNOBS];

    logic advance;
    logic proc;
    logic in_range;
    logic [KIDX_W-1:0] kidx;

    assign advance   = !out_valid_reg || rsp_ready;
    assign proc      = in_valid_reg && advance;
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

    assign in_range = (32'(in_word_reg.knob) < NUM_KNOBS);
    assign kidx     = KIDX_W'(in_word_reg.knob);

    // Current state of the addressed knob.
    logic [POS_W-1:0]  cur_pos;
    logic [1:0]        cur_prev_code;
    logic [POS_W-1:0]  cur_prev_pos;
    logic [MULT_W-1:0] cur_mult;
    logic [SLOT_W-1:0] cur_slot;
    ring_row_t         cur_row;
    logic [SUM_W-1:0]  cur_sum;
    logic [TIME_W-1:0] cur_last;
    logic [POS_W-1:0]  cur_ovpos;
    logic              cur_ovon;

    assign cur_pos       = pos_reg[kidx];
    assign cur_prev_code = prev_code_reg[kidx];
    assign cur_prev_pos  = prev_pos_reg[kidx];
    assign cur_mult      = mult_reg[kidx];
    assign cur_slot      = slot_reg[kidx];
    assign cur_row       = ring_reg[kidx];
    assign cur_sum       = sum_reg[kidx];
    assign cur_last      = last_reg[kidx];
    assign cur_ovpos     = ovpos_reg[kidx];
    assign cur_ovon      = ovon_reg[kidx];

    // Next state of the addressed knob.
    dir_t              dir;
    logic [POS_W:0]    up_sum;
    logic [POS_W-1:0]  new_pos;
    logic              rotated;
    logic              changed;
    logic [TIME_W-1:0] elapsed;
    logic [WAIT_W-1:0] wait_ms;
    logic [SLOT_W-1:0] slot_eff;
    logic [WAIT_W-1:0] old_wait;
    logic [SUM_W-1:0]  new_sum;
    logic [MULT_W-1:0] new_mult;
    logic [SLOT_W-1:0] slot_next;
    logic              ovon_after;
    logic [POS_W-1:0]  final_pos;
    ring_row_t         row_next;
    logic [VALUE_W-1:0] result_value;

    always_comb
    begin
        dir     = step_dir({cur_prev_code, in_word_reg.phase_a, in_word_reg.phase_b});
        up_sum  = {1'b0, cur_pos} + (POS_W + 1)'(cur_mult);
        rotated = (dir != DIR_NONE);

        case (dir)
            DIR_UP:
            begin
                new_pos = (up_sum > {1'b0, POS_MAX}) ? POS_MAX : up_sum[POS_W-1:0];
            end
            DIR_DOWN:
            begin
                new_pos = (cur_pos < POS_W'(cur_mult)) ? '0 : cur_pos - POS_W'(cur_mult);
            end
            default:
            begin
                new_pos = cur_pos;
            end
        endcase

        // A position that moved, including a jump left by an earlier
        // override, counts as a change and goes into the wait history.
        changed = (new_pos != cur_prev_pos);
        elapsed = in_word_reg.now_ms - cur_last;
        wait_ms = (elapsed > TIME_W'(WAIT_MAX)) ? WAIT_MAX : elapsed[WAIT_W-1:0];

        slot_eff = (32'(cur_slot) >= RING_DEPTH) ? '0 : cur_slot;
        old_wait = cur_row[slot_eff];
        row_next = cur_row;
        row_next[slot_eff] = wait_ms;

        // The running sum always equals the sum of the knob's ring row.
        new_sum = cur_sum - SUM_W'(old_wait) + SUM_W'(wait_ms);

        if (new_sum < SUM_W'(thresh.very_fast))
            new_mult = MULT_X5;
        else if (new_sum < SUM_W'(thresh.fast))
            new_mult = MULT_X4;
        else if (new_sum < SUM_W'(thresh.medium_fast))
            new_mult = MULT_X3;
        else if (new_sum < SUM_W'(thresh.moderate))
            new_mult = MULT_X2;
        else
            new_mult = MULT_X1;

        slot_next  = (32'(slot_eff) == RING_DEPTH - 1) ? '0 : slot_eff + SLOT_W'(1);
        ovon_after = rotated ? 1'b0 : cur_ovon;
        final_pos  = ovon_after ? cur_ovpos : new_pos;

        if (!in_range)
            result_value = '0;
        else if (in_word_reg.kind == KIND_PIN)
            result_value = final_pos[POS_W-1:1];
        else
            result_value = cur_pos[POS_W-1:1];
    end

    // Handshake registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_word_reg <= req;
        if (proc)
        begin
            out_word_reg.knob_out   <= in_word_reg.knob;
            out_word_reg.knob_value <= result_value;
        end
    end

    // Knob state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KNOBS; k++)
            begin
                pos_reg[k]       <= '0;
                prev_code_reg[k] <= '0;
                prev_pos_reg[k]  <= '0;
                mult_reg[k]      <= MULT_X1;
                slot_reg[k]      <= '0;
                ring_reg[k]      <= '0;
                sum_reg[k]       <= '0;
                last_reg[k]      <= '0;
                ovpos_reg[k]     <= '0;
                ovon_reg[k]      <= 1'b0;
            end
        end
        else if (proc && in_range)
        begin
            if (in_word_reg.kind == KIND_PIN)
            begin
                pos_reg[kidx]       <= final_pos;
                prev_code_reg[kidx] <= {in_word_reg.phase_a, in_word_reg.phase_b};
                ovon_reg[kidx]      <= ovon_after;
                if (changed)
                begin
                    prev_pos_reg[kidx] <= new_pos;
                    mult_reg[kidx]     <= new_mult;
                    slot_reg[kidx]     <= slot_next;
                    ring_reg[kidx]     <= row_next;
                    sum_reg[kidx]      <= new_sum;
                    last_reg[kidx]     <= in_word_reg.now_ms;
                end
            end
            else
            begin
                ovpos_reg[kidx] <= {in_word_reg.sync_value, 1'b0};
                ovon_reg[kidx]  <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (in_valid_reg && out_valid_reg && !rsp_ready))
        else $error("request side stalled while the pipeline had room");

    a_result_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(proc))
        else $error("result appeared without a processed word");

    a_sync_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_range && in_word_reg.kind == KIND_SYNC) |=> ovon_reg[$past(kidx)])
        else $error("sync write did not arm the override");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_range) |=> (32'(slot_reg[$past(kidx)]) < RING_DEPTH))
        else $error("ring slot left its range");

    a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_range) |=> (pos_reg[$past(kidx)] <= POS_MAX))
        else $error("knob position beyond its maximum");
`endif

endmodule
